[design/tlmd_pkg.sv]
package tlmd_pkg;

    localparam int unsigned LIMIT_W  = 30;
    localparam int unsigned LENGTH_W = 32;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned COUNT_W  = 3;
    localparam int unsigned APB_DW   = 32;
    localparam int unsigned APB_AW   = 3;

    localparam logic [LIMIT_W-1:0]  SHORT_LIMIT_RESET = LIMIT_W'(30000);
    localparam logic [LIMIT_W-1:0]  LARGE_LIMIT_RESET = LIMIT_W'(30'h3fff_ffff);
    localparam logic [COUNT_W-1:0]  HEADER_BYTES      = COUNT_W'(5);
    localparam logic [LENGTH_W-1:0] MIN_LENGTH        = LENGTH_W'(4);

    // Register index, taken from paddr[2] (registers sit on a 4-byte stride).
    localparam logic REG_SHORT_LIMIT = 1'b0;
    localparam logic REG_LARGE_LIMIT = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_HEADER     = 3'd0,
        ST_PAYLOAD    = 3'd1,
        ST_BAD_LENGTH = 3'd2,
        ST_EARLY_END  = 3'd3,
        ST_DROPPED    = 3'd4
    } t_byte_status;

    // Data-bearing message tags may use the large length limit.
    function automatic logic tag_is_large(input logic [BYTE_W-1:0] tag);
        tag_is_large = (tag == BYTE_W'("d")) || (tag == BYTE_W'("D")) ||
                       (tag == BYTE_W'("E")) || (tag == BYTE_W'("V")) ||
                       (tag == BYTE_W'("N")) || (tag == BYTE_W'("A")) ||
                       (tag == BYTE_W'("T")) || (tag == BYTE_W'("t"));
    endfunction

endpackage

[design/tlmd_stream_if.sv]
interface tlmd_in_if;
    logic                         valid;
    logic                         ready;
    logic [tlmd_pkg::BYTE_W-1:0]  rx_byte;
    logic                         end_of_stream;

    modport source (output valid, rx_byte, end_of_stream, input ready);
    modport sink   (input valid, rx_byte, end_of_stream, output ready);
endinterface

interface tlmd_out_if;
    logic                           valid;
    logic                           ready;
    logic [tlmd_pkg::BYTE_W-1:0]    out_byte;
    logic [tlmd_pkg::BYTE_W-1:0]    msg_tag;
    logic [tlmd_pkg::LENGTH_W-1:0]  msg_length;
    logic [tlmd_pkg::STATUS_W-1:0]  byte_status;
    logic                           last_of_message;

    modport source (output valid, out_byte, msg_tag, msg_length, byte_status,
                    last_of_message, input ready);
    modport sink   (input valid, out_byte, msg_tag, msg_length, byte_status,
                    last_of_message, output ready);
endinterface

[design/tagged_length_message_deframer_core.sv]
// The result of each accepted input transaction is registered and shown on the output channel.
// One byte per cycle unless the output stalls; the single result register refills as it drains.
// Reset (i_rst_n, synchronous, active low) clears the framing state, the failure flag and the
// output valid, and loads the short and large length limits with their default values.
// After a failure only reset brings the block back to framing.
module tagged_length_message_deframer_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    tlmd_in_if.sink                       i_in,
    tlmd_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tlmd_pkg::APB_AW-1:0]   paddr,
    input  logic [tlmd_pkg::APB_DW-1:0]   pwdata,
    output logic [tlmd_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    // ------------------------------------------------------------------
    // Configuration registers. A write lands in the access phase; the
    // register index is address bit 2, so every address maps to one of
    // the two limits.
    // ------------------------------------------------------------------
    logic [tlmd_pkg::LIMIT_W-1:0] r_short_limit;
    logic [tlmd_pkg::LIMIT_W-1:0] r_large_limit;
    logic                         cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_limit <= tlmd_pkg::SHORT_LIMIT_RESET;
            r_large_limit <= tlmd_pkg::LARGE_LIMIT_RESET;
        end else if (cfg_write) begin
            case (paddr[2])
                tlmd_pkg::REG_SHORT_LIMIT: r_short_limit <= pwdata[tlmd_pkg::LIMIT_W-1:0];
                tlmd_pkg::REG_LARGE_LIMIT: r_large_limit <= pwdata[tlmd_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            tlmd_pkg::REG_SHORT_LIMIT:
                prdata = {{(tlmd_pkg::APB_DW-tlmd_pkg::LIMIT_W){1'b0}}, r_short_limit};
            tlmd_pkg::REG_LARGE_LIMIT:
                prdata = {{(tlmd_pkg::APB_DW-tlmd_pkg::LIMIT_W){1'b0}}, r_large_limit};
            default:
                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Framing state. The header counter runs 0..4 through the tag and
    // length bytes and sits at five while payload bytes stream through.
    // ------------------------------------------------------------------
    logic [tlmd_pkg::COUNT_W-1:0]  r_header_count, n_header_count;
    logic [tlmd_pkg::BYTE_W-1:0]   r_tag_hold, n_tag_hold;
    logic [tlmd_pkg::LENGTH_W-1:0] r_length_hold, n_length_hold;
    logic [tlmd_pkg::LIMIT_W-1:0]  r_payload_remaining, n_payload_remaining;
    logic                          r_failed, n_failed;

    // Result register, which also serves as the output stage.
    logic                          r_out_valid;
    logic [tlmd_pkg::BYTE_W-1:0]   r_out_byte, n_out_byte;
    tlmd_pkg::t_byte_status        r_status, n_status;
    logic                          r_last, n_last;

    logic                          in_accept;
    logic [tlmd_pkg::COUNT_W-1:0]  count_inc;
    logic [tlmd_pkg::LENGTH_W-1:0] length_shifted;
    logic [tlmd_pkg::LENGTH_W-1:0] length_minus_min;
    logic [tlmd_pkg::LIMIT_W-1:0]  limit_sel;
    logic                          length_bad;

    // The input is taken whenever the result register is empty or is being
    // drained in this same cycle, so a byte can enter on every clock.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_accept  = i_in.valid && i_in.ready;

    assign count_inc        = r_header_count + tlmd_pkg::COUNT_W'(1);
    assign length_shifted   = {r_length_hold[tlmd_pkg::LENGTH_W-tlmd_pkg::BYTE_W-1:0],
                               i_in.rx_byte};
    assign length_minus_min = length_shifted - tlmd_pkg::MIN_LENGTH;
    assign limit_sel        = tlmd_pkg::tag_is_large(r_tag_hold) ? r_large_limit
                                                                 : r_short_limit;
    // The length check happens on the fifth header byte, against the
    // freshly completed length word.
    assign length_bad = (length_shifted < tlmd_pkg::MIN_LENGTH) ||
                        (length_shifted >
                         {{(tlmd_pkg::LENGTH_W-tlmd_pkg::LIMIT_W){1'b0}}, limit_sel});

    always_comb begin
        n_header_count      = r_header_count;
        n_tag_hold          = r_tag_hold;
        n_length_hold       = r_length_hold;
        n_payload_remaining = r_payload_remaining;
        n_failed            = r_failed;
        n_out_byte          = i_in.end_of_stream ? '0 : i_in.rx_byte;
        n_status            = tlmd_pkg::ST_HEADER;
        n_last              = 1'b0;

        if (r_failed) begin
            // Everything after a failure is passed through as dropped.
            n_status = tlmd_pkg::ST_DROPPED;
        end else if (i_in.end_of_stream) begin
            n_status = tlmd_pkg::ST_EARLY_END;
            n_failed = 1'b1;
        end else if (r_header_count == '0) begin
            // Tag byte opens a new message.
            n_tag_hold     = i_in.rx_byte;
            n_length_hold  = '0;
            n_header_count = count_inc;
        end else if (r_header_count < tlmd_pkg::HEADER_BYTES) begin
            n_length_hold  = length_shifted;
            n_header_count = count_inc;
            if (count_inc == tlmd_pkg::HEADER_BYTES) begin
                if (length_bad) begin
                    n_status = tlmd_pkg::ST_BAD_LENGTH;
                    n_failed = 1'b1;
                end else begin
                    n_payload_remaining = length_minus_min[tlmd_pkg::LIMIT_W-1:0];
                    // A message with an empty payload ends on its last header byte.
                    if (length_minus_min == '0) begin
                        n_last         = 1'b1;
                        n_header_count = '0;
                    end
                end
            end
        end else begin
            n_status = tlmd_pkg::ST_PAYLOAD;
            if (r_payload_remaining <= tlmd_pkg::LIMIT_W'(1)) begin
                n_payload_remaining = '0;
                n_last              = 1'b1;
                n_header_count      = '0;
            end else begin
                n_payload_remaining = r_payload_remaining - tlmd_pkg::LIMIT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_count      <= '0;
            r_tag_hold          <= '0;
            r_length_hold       <= '0;
            r_payload_remaining <= '0;
            r_failed            <= 1'b0;
            r_out_valid         <= 1'b0;
        end else begin
            if (in_accept) begin
                r_header_count      <= n_header_count;
                r_tag_hold          <= n_tag_hold;
                r_length_hold       <= n_length_hold;
                r_payload_remaining <= n_payload_remaining;
                r_failed            <= n_failed;
                r_out_valid         <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid         <= 1'b0;
            end
        end
    end

    // Result payload: loaded with each accepted transaction, no reset needed.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_byte <= n_out_byte;
            r_status   <= n_status;
            r_last     <= n_last;
        end
    end

    // The held tag and length are the post-transaction state, so they are
    // shown straight from the state registers.
    assign o_out.valid           = r_out_valid;
    assign o_out.out_byte        = r_out_byte;
    assign o_out.msg_tag         = r_tag_hold;
    assign o_out.msg_length      = r_length_hold;
    assign o_out.byte_status     = r_status;
    assign o_out.last_of_message = r_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_failed_sticks : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_failed |=> r_failed)
        else $error("failure flag cleared without reset");

    a_count_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_header_count <= tlmd_pkg::HEADER_BYTES)
        else $error("header counter out of range");

    a_last_rearms : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && n_last) |=> (r_header_count == '0))
        else $error("framing not rearmed after last byte of message");

    a_error_fails : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (n_status == tlmd_pkg::ST_BAD_LENGTH ||
                       n_status == tlmd_pkg::ST_EARLY_END)) |=> r_failed)
        else $error("error reported without entering failure");

    a_last_only_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_last) |->
            (r_status == tlmd_pkg::ST_HEADER || r_status == tlmd_pkg::ST_PAYLOAD))
        else $error("end of message marked on an error or dropped byte");

endmodule

[tb/testbench.sv]
module testbench;
    import tlmd_pkg::*;

    // Tags that are checked against the large length limit; all others use the short one.
    localparam logic [BYTE_W-1:0] DATA_TAGS [8] = '{"d", "D", "E", "V", "N", "A", "T", "t"};
    localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;
    localparam int unsigned TIMEOUT_CYCLES = 300000;
    localparam int unsigned PRESSURE_CYCLES = 400;

    // One result transaction as it leaves the block.
    typedef struct packed {
        logic [BYTE_W-1:0]   out_byte;
        logic [BYTE_W-1:0]   tag;
        logic [LENGTH_W-1:0] length;
        logic [STATUS_W-1:0] status;
        logic                last;
    } t_deframe_word;

    // Tracks the framing state of the byte stream, predicts the result of every accepted
    // byte and checks the results that come out in order against those predictions.
    class t_deframe_predictor;
        logic [LIMIT_W-1:0]  short_limit;
        logic [LIMIT_W-1:0]  large_limit;
        logic [COUNT_W-1:0]  header_seen;
        logic [BYTE_W-1:0]   tag;
        logic [LENGTH_W-1:0] length;
        logic [LIMIT_W-1:0]  remaining;
        bit                  failed;
        t_deframe_word       expected_words[$];
        int unsigned         mismatches;
        int unsigned         words_checked;

        function new();
            short_limit   = SHORT_LIMIT_RESET;
            large_limit   = LARGE_LIMIT_RESET;
            header_seen   = '0;
            tag           = '0;
            length        = '0;
            remaining     = '0;
            failed        = 1'b0;
            mismatches    = 0;
            words_checked = 0;
        endfunction

        function bit is_data_tag(logic [BYTE_W-1:0] candidate);
            foreach (DATA_TAGS[i]) begin
                if (candidate == DATA_TAGS[i]) return 1'b1;
            end
            return 1'b0;
        endfunction

        function void set_limit(logic index, logic [LIMIT_W-1:0] value);
            if (index == REG_SHORT_LIMIT) begin
                short_limit = value;
            end else begin
                large_limit = value;
            end
        endfunction

        function logic [LIMIT_W-1:0] limit_of(logic index);
            return (index == REG_SHORT_LIMIT) ? short_limit : large_limit;
        endfunction

        function int unsigned pending();
            return expected_words.size();
        endfunction

        // Advances the framing state by one accepted byte and queues its expected result.
        function void note_input(logic [BYTE_W-1:0] value, logic eos);
            t_deframe_word      word;
            t_byte_status       status;
            logic [LIMIT_W-1:0] limit;
            word.out_byte = eos ? '0 : value;
            word.last     = 1'b0;
            if (failed) begin
                status = ST_DROPPED;
            end else if (eos) begin
                status = ST_EARLY_END;
                failed = 1'b1;
            end else if (header_seen == 0) begin
                tag         = value;
                length      = '0;
                header_seen = COUNT_W'(1);
                status      = ST_HEADER;
            end else if (header_seen < HEADER_BYTES) begin
                length      = {length[LENGTH_W-BYTE_W-1:0], value};
                header_seen = header_seen + 1'b1;
                status      = ST_HEADER;
                if (header_seen == HEADER_BYTES) begin
                    limit = is_data_tag(tag) ? large_limit : short_limit;
                    if (length < MIN_LENGTH || length > LENGTH_W'(limit)) begin
                        status = ST_BAD_LENGTH;
                        failed = 1'b1;
                    end else begin
                        remaining = LIMIT_W'(length - MIN_LENGTH);
                        if (remaining == 0) begin
                            word.last   = 1'b1;
                            header_seen = '0;
                        end
                    end
                end
            end else begin
                status = ST_PAYLOAD;
                if (remaining <= 1) begin
                    remaining   = '0;
                    word.last   = 1'b1;
                    header_seen = '0;
                end else begin
                    remaining = remaining - 1'b1;
                end
            end
            word.status = status;
            word.tag    = tag;
            word.length = length;
            expected_words.insert(expected_words.size(), word);
        endfunction

        task report(string what);
            mismatches++;
            $display("MISMATCH at %0t: %s", $time, what);
        endtask

        task check_word(t_deframe_word seen);
            t_deframe_word want;
            if (expected_words.size() == 0) begin
                report($sformatf("result with nothing expected: %p", seen));
                return;
            end
            want = expected_words.pop_front();
            if (seen.out_byte !== want.out_byte)
                report($sformatf("result %0d out_byte %h, expected %h",
                                 words_checked, seen.out_byte, want.out_byte));
            if (seen.tag !== want.tag)
                report($sformatf("result %0d msg_tag %h, expected %h",
                                 words_checked, seen.tag, want.tag));
            if (seen.length !== want.length)
                report($sformatf("result %0d msg_length %h, expected %h",
                                 words_checked, seen.length, want.length));
            if (seen.status !== want.status)
                report($sformatf("result %0d byte_status %0d, expected %0d",
                                 words_checked, seen.status, want.status));
            if (seen.last !== want.last)
                report($sformatf("result %0d last_of_message %b, expected %b",
                                 words_checked, seen.last, want.last));
            words_checked++;
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [APB_AW-1:0]  paddr;
    logic [APB_DW-1:0]  pwdata;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    tlmd_in_if  in_ch ();
    tlmd_out_if out_ch ();

    t_deframe_predictor deframer = new();

    // Per-cycle chances, in percent, that the sender leaves a gap or the receiver stalls.
    int unsigned send_idle_pct    = 0;
    int unsigned recv_stall_pct   = 0;
    // Cycles for which the receiver holds ready low no matter what; counted down below.
    int unsigned recv_hold_cycles = 0;
    int unsigned bytes_sent       = 0;

    tagged_length_message_deframer_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Both channels are watched at the rising edge, where the values settled during the
    // previous low phase are the ones the block itself sees. An input transaction feeds the
    // predictor and an output transaction is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            deframer.note_input(in_ch.rx_byte, in_ch.end_of_stream);
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            deframer.check_word({out_ch.out_byte, out_ch.msg_tag, out_ch.msg_length,
                                 out_ch.byte_status, out_ch.last_of_message});
        end
    end

    // The receiver decides ready at every falling edge. A requested hold-off overrides the
    // random stalls so that the single result register fills and the input backs up.
    always @(negedge i_clk) begin
        if (recv_hold_cycles > 0) begin
            out_ch.ready <= 1'b0;
            recv_hold_cycles--;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offers one byte, possibly after some idle cycles, and returns at the falling edge after
    // the transaction has been accepted. valid is left high so back-to-back bytes need no
    // second assignment in the same time step.
    task automatic send_item(input logic [BYTE_W-1:0] value, input logic eos);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.rx_byte       <= value;
        in_ch.end_of_stream <= eos;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    // Sends a tag, the big-endian length and a number of random payload bytes.
    task automatic send_message(input logic [BYTE_W-1:0] tag, input logic [LENGTH_W-1:0] length,
                                input int unsigned payload_bytes);
        send_item(tag, 1'b0);
        for (int i = 3; i >= 0; i--) send_item(length[8*i +: 8], 1'b0);
        for (int unsigned i = 0; i < payload_bytes; i++) send_item(8'($urandom_range(255)), 1'b0);
    endtask

    // A well-formed message for the current limits. Lengths stay short so that messages
    // end quickly; where a limit is small the length sits right on it a quarter of the time,
    // and now and then a length above 255 exercises the upper length bytes.
    task automatic send_random_message();
        logic [BYTE_W-1:0]  tag;
        logic [LIMIT_W-1:0] limit;
        int unsigned        cap;
        int unsigned        length;
        tag   = $urandom_range(1) ? DATA_TAGS[$urandom_range(7)] : 8'($urandom_range(255));
        limit = deframer.is_data_tag(tag) ? deframer.large_limit : deframer.short_limit;
        cap   = (limit < 40) ? 32'(limit) : 40;
        if (limit <= 64 && $urandom_range(3) == 0) begin
            length = 32'(limit);
        end else if (limit >= 300 && $urandom_range(15) == 0) begin
            length = $urandom_range(300, 256);
        end else begin
            length = $urandom_range(cap, 4);
        end
        send_message(tag, length, length - 4);
    endtask

    // Stops offering and waits at falling edges until every predicted result has come out.
    task automatic wait_for_results();
        in_ch.valid <= 1'b0;
        while (deframer.pending() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    // APB read of a limit register, compared with the predictor's copy. The bus is left idle
    // before the task returns, so the next transfer starts at a later falling edge.
    task automatic read_limit(input logic index);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= APB_AW'({index, 2'b00});
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== APB_DW'(deframer.limit_of(index)))
            deframer.report($sformatf("register %0d reads %h, expected %h",
                                      index, prdata, deframer.limit_of(index)));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // APB write of a limit register (setup, then access), followed by a read-back.
    task automatic write_limit(input logic index, input logic [LIMIT_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({index, 2'b00});
        pwdata  <= APB_DW'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        deframer.set_limit(index, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        read_limit(index);
    endtask

    initial begin
        logic [BYTE_W-1:0]   tag;
        logic [LENGTH_W-1:0] length;
        int unsigned         target;
        int unsigned         kind;

        i_rst_n              = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        in_ch.valid          = 1'b0;
        in_ch.rx_byte        = '0;
        in_ch.end_of_stream  = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Both limits must come out of reset at their defaults.
        read_limit(REG_SHORT_LIMIT);
        read_limit(REG_LARGE_LIMIT);

        // Directed messages with the default limits: an empty payload with tag zero, a tag of
        // all ones whose payload carries the extreme byte values, and a data tag.
        send_message(8'h00, 4, 0);
        send_message(8'hff, 6, 0);
        send_item(8'hff, 1'b0);
        send_item(8'h00, 1'b0);
        send_message("d", 5, 1);
        wait_for_results();

        // Both limits at their lowest: only empty messages are still legal.
        write_limit(REG_SHORT_LIMIT, LIMIT_W'(4));
        write_limit(REG_LARGE_LIMIT, LIMIT_W'(4));
        send_message("Q", 4, 0);
        send_message("t", 4, 0);
        wait_for_results();

        // Random phases. Each phase loads its own limits, then sends two halves of random
        // messages with a full drain between them; the idle pattern rotates through no idling,
        // a lazy sender, a stalling receiver and both at once.
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    write_limit(REG_SHORT_LIMIT, LIMIT_MAX);
                    write_limit(REG_LARGE_LIMIT, LIMIT_MAX);
                end
                1: begin
                    write_limit(REG_SHORT_LIMIT, LIMIT_W'(4));
                    write_limit(REG_LARGE_LIMIT, LIMIT_W'($urandom_range(64, 4)));
                end
                2: begin
                    write_limit(REG_SHORT_LIMIT, LIMIT_W'($urandom_range(64, 4)));
                    write_limit(REG_LARGE_LIMIT, LIMIT_W'(4));
                end
                default: begin
                    write_limit(REG_SHORT_LIMIT, LIMIT_W'($urandom_range(64, 4)));
                    write_limit(REG_LARGE_LIMIT,
                                $urandom_range(3) == 0 ? LIMIT_MAX
                                                       : LIMIT_W'($urandom_range(64, 4)));
                end
            endcase
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            if (phase == 0) begin
                // Long receiver hold-off while the sender keeps pushing bytes, so the output
                // register fills and the input side has to stall.
                @(posedge i_clk);
                recv_hold_cycles = PRESSURE_CYCLES;
                @(negedge i_clk);
            end
            for (int half = 0; half < 2; half++) begin
                target = bytes_sent + 90;
                while (bytes_sent < target) send_random_message();
                wait_for_results();
            end
        end

        // A failure is permanent until reset, so exactly one failure is provoked at the very
        // end, chosen at random, followed by bytes that must all be reported as dropped.
        write_limit(REG_SHORT_LIMIT, LIMIT_W'($urandom_range(64, 4)));
        write_limit(REG_LARGE_LIMIT, LIMIT_MAX);
        kind = $urandom_range(4);
        case (kind)
            0: begin
                // Stream closes cleanly between two messages.
                send_random_message();
                send_item(8'($urandom_range(255)), 1'b1);
            end
            1: begin
                // Stream closes part way through a header.
                send_item(8'($urandom_range(255)), 1'b0);
                repeat ($urandom_range(3)) send_item(8'($urandom_range(255)), 1'b0);
                send_item(8'($urandom_range(255)), 1'b1);
            end
            2: begin
                // Length too small to even cover its own four bytes.
                send_message(8'($urandom_range(255)), $urandom_range(3), 0);
            end
            3: begin
                // Ordinary tag with a length above its limit, just over or far beyond.
                do tag = 8'($urandom_range(255)); while (deframer.is_data_tag(tag));
                length = $urandom_range(1) ? (32'($urandom()) | 32'h4000_0000)
                                           : deframer.short_limit + 1 + $urandom_range(50);
                send_message(tag, length, 0);
            end
            default: begin
                // Largest legal length on a data tag; the stream ends inside the payload.
                send_message(DATA_TAGS[$urandom_range(7)], LENGTH_W'(LIMIT_MAX),
                             $urandom_range(20, 1));
                send_item(8'($urandom_range(255)), 1'b1);
            end
        endcase
        repeat (40) send_item(8'($urandom_range(255)), ($urandom_range(3) == 0));

        wait_for_results();
        repeat (10) @(negedge i_clk);
        if (deframer.mismatches == 0 && deframer.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * 8);
        $display("Test completed with failures");
        $finish;
    end

endmodule

[sim.f]
design/tlmd_pkg.sv
design/tlmd_stream_if.sv
design/tagged_length_message_deframer_core.sv
tb/testbench.sv
